[rtl/ray_refraction_snell_assert.svh]
// Assertion macros shared by the refraction pipeline modules.
// No dependencies; taken in by `include where checks are written.
`ifndef RAY_REFRACTION_SNELL_ASSERT_SVH
`define RAY_REFRACTION_SNELL_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, quiet while in reset.
`define RRS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet while in reset.
`define RRS_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/rrs_pkg.sv]
// Constants, word types and step functions for the refraction pipeline.
// No dependencies; imported by every module of the block.
package rrs_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int VW          = 24;                // vector component width
	localparam int EW          = 20;                // index ratio width
	localparam int NSH         = 7;                 // headroom of the norm root
	localparam int SQ_W        = 2 * VW - 1;        // one square, never negative
	localparam int SUM_W       = SQ_W + 2;
	localparam int RT_W        = 31;                // root width of both square roots
	localparam int SX_W        = 2 * RT_W;          // radicand width
	localparam int STEP_PER_ST = 4;                 // iterations per pipeline stage
	localparam int SQ_ST       = (RT_W + STEP_PER_ST - 1) / STEP_PER_ST;
	localparam int QB          = FRAC_BITS + 2;     // quotient bits of the normaliser
	localparam int DIV_ST      = (QB + STEP_PER_ST - 1) / STEP_PER_ST;
	localparam int TOP_W       = VW + FRAC_BITS + NSH - QB;
	localparam int U_W         = FRAC_BITS + 2;     // normalised component, signed
	localparam int P_W         = U_W + VW;
	localparam int DS_W        = P_W + 2;
	localparam int DT_W        = DS_W - FRAC_BITS;
	localparam int EE_W        = 2 * EW;
	localparam int E2_W        = EE_W - FRAC_BITS;
	localparam int DD_W        = 2 * DT_W;
	localparam int DT2_W       = DD_W - FRAC_BITS;
	localparam int OMF_W       = DT2_W + 2;
	localparam int OM_W        = FRAC_BITS + 22;
	localparam int ND_W        = VW + DT_W;
	localparam int NDS_W       = ND_W - FRAC_BITS;
	localparam int T_W         = NDS_W + 1;
	localparam int EO_W        = E2_W + 1 + OM_W;
	localparam int DISC_W      = EO_W - FRAC_BITS + 1;
	localparam int A_W         = EW + 1 + T_W;
	localparam int B_W         = VW + RT_W + 1;
	localparam int R_W         = A_W - FRAC_BITS + 1;

	localparam logic [QB-1:0] Q_ONE = {2'b01, {FRAC_BITS{1'b0}}};

	// Normalised direction, normal and ratio handed to the discriminant part
	typedef struct packed {
		logic [2:0][U_W-1:0] u;
		logic [2:0][VW-1:0]  n;
		logic [EW-1:0]       eta;
	} nrm_res_t;

	// Tangential term, normal, ratio and root handed to the output part
	typedef struct packed {
		logic [2:0][T_W-1:0] t;
		logic [2:0][VW-1:0]  n;
		logic [EW-1:0]       eta;
		logic [RT_W-1:0]     s;
		logic                tir;
	} dsc_res_t;

	typedef struct packed {
		logic [RT_W+1:0] rem;
		logic [RT_W-1:0] root;
	} sq_state_t;

	typedef struct packed {
		logic            hit;
		logic [RT_W-1:0] rem;
	} dv_step_t;

	// One digit of a restoring square root: take two radicand bits, yield one root bit
	function automatic sq_state_t sqrt_step(input sq_state_t cur, input logic [1:0] pair);
		sq_state_t       nxt;
		logic [RT_W+1:0] acc;
		logic [RT_W+1:0] trial;
		acc   = {cur.rem[RT_W-1:0], pair};
		trial = {cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = acc - trial;
			nxt.root = {cur.root[RT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc;
			nxt.root = {cur.root[RT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// One digit of a restoring division; the dividend bits shifted in are zero
	function automatic dv_step_t div_step(input logic [RT_W-1:0] rem, input logic [RT_W-1:0] dvs);
		dv_step_t    r;
		logic [RT_W:0] acc;
		acc = {rem, 1'b0};
		if (acc >= {1'b0, dvs}) begin
			r.hit = 1'b1;
			r.rem = RT_W'(acc - {1'b0, dvs});
		end else begin
			r.hit = 1'b0;
			r.rem = acc[RT_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/rrs_norm.sv]
// Direction normaliser: sum of squares, pipelined root, pipelined divide.
// Depends on rrs_pkg and ray_refraction_snell_assert.svh.
`include "ray_refraction_snell_assert.svh"
module rrs_norm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic [2:0][rrs_pkg::VW-1:0]     dir,
	input  logic [2:0][rrs_pkg::VW-1:0]     nrm,
	input  logic [rrs_pkg::EW-1:0]          eta,
	output logic                            out_vld,
	output rrs_pkg::nrm_res_t               res
);
	import rrs_pkg::*;

	typedef struct packed {
		logic [2:0][VW-1:0] v;
		logic [2:0][VW-1:0] n;
		logic [EW-1:0]      eta;
	} ray_t;

	typedef struct packed {
		sq_state_t       st;
		logic [SX_W-1:0] x;
		ray_t            ray;
	} rt_t;

	typedef struct packed {
		logic [2:0][RT_W-1:0] rem;
		logic [2:0][QB-1:0]   q;
		logic [2:0]           ovf;
		logic [2:0]           neg;
		logic [RT_W-1:0]      m;
		logic [2:0][VW-1:0]   n;
		logic [EW-1:0]        eta;
	} dv_t;

	// stage 1: squares of the raw components
	logic                     vld_s1;
	ray_t                     ray_s1;
	logic [2:0][SQ_W-1:0]     sq_s1;
	logic signed [2*VW-1:0]   sq_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = $signed(dir[i]) * $signed(dir[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= '{v: dir, n: nrm, eta: eta};
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= sq_c[i][SQ_W-1:0];
			end
		end
	end

	// stage 2: sum of squares, scaled into the radicand
	logic             vld_s2;
	ray_t             ray_s2;
	logic [SX_W-1:0]  x_s2;
	logic [SUM_W-1:0] sum_c;

	assign sum_c = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_s1;
			x_s2   <= {sum_c[SX_W-2*NSH-1:0], {(2*NSH){1'b0}}};
		end
	end

	// root stages: STEP_PER_ST digits of the norm root in each
	rt_t  rt_s     [SQ_ST];
	logic rt_vld_s [SQ_ST];

	for (genvar k = 0; k < SQ_ST; k++) begin : g_rt
		rt_t  prv;
		rt_t  nxt;
		logic prv_vld;

		if (k == 0) begin : g_head
			assign prv     = '{st: '0, x: x_s2, ray: ray_s2};
			assign prv_vld = vld_s2;
		end else begin : g_body
			assign prv     = rt_s[k-1];
			assign prv_vld = rt_vld_s[k-1];
		end

		always_comb begin
			nxt = prv;
			for (int j = 0; j < STEP_PER_ST; j++) begin
				if (k * STEP_PER_ST + j < RT_W) begin
					nxt.st = sqrt_step(nxt.st, nxt.x[SX_W-1 -: 2]);
					nxt.x  = nxt.x << 2;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= nxt;
			end
		end
	end

	// stage 3: magnitudes, overflow check and first partial remainder
	logic            vld_s3;
	dv_t             dv_s3;
	dv_t             dv_c;
	rt_t             rt_last;
	logic [VW-1:0]   mag_c [3];
	logic [TOP_W-1:0] top_c [3];

	assign rt_last = rt_s[SQ_ST-1];

	always_comb begin
		dv_c.m   = rt_last.st.root;
		dv_c.n   = rt_last.ray.n;
		dv_c.eta = rt_last.ray.eta;
		dv_c.q   = '0;
		for (int i = 0; i < 3; i++) begin
			dv_c.neg[i] = rt_last.ray.v[i][VW-1];
			mag_c[i]    = rt_last.ray.v[i][VW-1] ? (~rt_last.ray.v[i] + 1'b1) : rt_last.ray.v[i];
			top_c[i]    = {mag_c[i], {(TOP_W-VW){1'b0}}};
			dv_c.ovf[i] = RT_W'(top_c[i]) >= rt_last.st.root;
			dv_c.rem[i] = dv_c.ovf[i] ? '0 : RT_W'(top_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= rt_vld_s[SQ_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s3 <= dv_c;
		end
	end

	// divide stages: STEP_PER_ST quotient bits of each lane in each
	dv_t  dv_s     [DIV_ST];
	logic dv_vld_s [DIV_ST];

	for (genvar k = 0; k < DIV_ST; k++) begin : g_dv
		dv_t      prv;
		dv_t      nxt;
		logic     prv_vld;
		dv_step_t stp;

		if (k == 0) begin : g_head
			assign prv     = dv_s3;
			assign prv_vld = vld_s3;
		end else begin : g_body
			assign prv     = dv_s[k-1];
			assign prv_vld = dv_vld_s[k-1];
		end

		always_comb begin
			nxt = prv;
			stp = '0;
			for (int j = 0; j < STEP_PER_ST; j++) begin
				if (k * STEP_PER_ST + j < QB) begin
					for (int i = 0; i < 3; i++) begin
						stp         = div_step(nxt.rem[i], nxt.m);
						nxt.rem[i]  = stp.rem;
						nxt.q[i]    = {nxt.q[i][QB-2:0], stp.hit};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nxt;
			end
		end
	end

	// stage 4: clamp to one, restore sign, zero direction gives zero
	logic        vld_s4;
	nrm_res_t    res_s4;
	nrm_res_t    res_c;
	dv_t         dv_last;
	logic [QB-1:0] qc_c [3];

	assign dv_last = dv_s[DIV_ST-1];

	always_comb begin
		res_c.n   = dv_last.n;
		res_c.eta = dv_last.eta;
		for (int i = 0; i < 3; i++) begin
			if (dv_last.m == '0) begin
				qc_c[i] = '0;
			end else if (dv_last.ovf[i] || dv_last.q[i] > Q_ONE) begin
				qc_c[i] = Q_ONE;
			end else begin
				qc_c[i] = dv_last.q[i];
			end
			res_c.u[i] = dv_last.neg[i] ? U_W'(-qc_c[i]) : U_W'(qc_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= dv_vld_s[DIV_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_c;
		end
	end

	assign out_vld = vld_s4;
	assign res     = res_s4;

	// a normalised component never exceeds one in magnitude
	logic u_in_range;
	always_comb begin
		u_in_range = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if ($signed(res_s4.u[i]) > $signed({2'b00, {FRAC_BITS{1'b0}}} | U_W'(Q_ONE)) ||
			    $signed(res_s4.u[i]) < -$signed(U_W'(Q_ONE))) begin
				u_in_range = 1'b0;
			end
		end
	end

	`RRS_ASSERT_IMP(a_u_bound, clk, arst_n, vld_s4, u_in_range, "normalised component beyond one")

endmodule

[rtl/rrs_disc.sv]
// Discriminant part: dot product, 1 - eta^2(1 - dt^2), tangential term, pipelined root.
// Depends on rrs_pkg and ray_refraction_snell_assert.svh.
`include "ray_refraction_snell_assert.svh"
module rrs_disc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  rrs_pkg::nrm_res_t   din,
	output logic                out_vld,
	output rrs_pkg::dsc_res_t   res
);
	import rrs_pkg::*;

	localparam logic signed [OMF_W-1:0] OMF_ONE = OMF_W'(longint'(1) <<< FRAC_BITS);
	localparam logic signed [OMF_W-1:0] OM_MIN  = OMF_W'(-(longint'(1) <<< (FRAC_BITS + 20)));
	localparam logic signed [DISC_W-1:0] DISC_ONE = DISC_W'(longint'(1) <<< FRAC_BITS);

	typedef struct packed {
		logic [2:0][T_W-1:0] t;
		logic [2:0][VW-1:0]  n;
		logic [EW-1:0]       eta;
		logic                tir;
	} cx_t;

	typedef struct packed {
		sq_state_t       st;
		logic [SX_W-1:0] x;
		cx_t             cx;
	} rt_t;

	// stage 1: lane products of the dot product, square of the ratio
	logic                   vld_s1;
	nrm_res_t               d_s1;
	logic [2:0][P_W-1:0]    p_s1;
	logic [EE_W-1:0]        ee_s1;
	logic signed [P_W-1:0]  p_c [3];
	logic [EE_W-1:0]        ee_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i] = $signed(din.u[i]) * $signed(din.n[i]);
		end
		ee_c = din.eta * din.eta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= din;
			ee_s1 <= ee_c;
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= p_c[i];
			end
		end
	end

	// stage 2: dt and eta^2, both floored back to the fixed-point grid
	logic                   vld_s2;
	nrm_res_t               d_s2;
	logic [DT_W-1:0]        dt_s2;
	logic [E2_W-1:0]        e2_s2;
	logic signed [DS_W-1:0] ds_c;

	assign ds_c = DS_W'($signed(p_s1[0])) + DS_W'($signed(p_s1[1])) + DS_W'($signed(p_s1[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2  <= d_s1;
			dt_s2 <= ds_c[DS_W-1:FRAC_BITS];
			e2_s2 <= ee_s1[EE_W-1:FRAC_BITS];
		end
	end

	// stage 3: dt^2 and the normal scaled by dt
	logic                    vld_s3;
	nrm_res_t                d_s3;
	logic [E2_W-1:0]         e2_s3;
	logic [DD_W-1:0]         dd_s3;
	logic [2:0][ND_W-1:0]    nd_s3;
	logic signed [DD_W-1:0]  dd_c;
	logic signed [ND_W-1:0]  nd_c [3];

	always_comb begin
		dd_c = $signed(dt_s2) * $signed(dt_s2);
		for (int i = 0; i < 3; i++) begin
			nd_c[i] = $signed(d_s2.n[i]) * $signed(dt_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= d_s2;
			e2_s3 <= e2_s2;
			dd_s3 <= dd_c;
			for (int i = 0; i < 3; i++) begin
				nd_s3[i] <= nd_c[i];
			end
		end
	end

	// stage 4: 1 - dt^2 clamped from below, tangential term u - n*dt
	logic                    vld_s4;
	logic [E2_W-1:0]         e2_s4;
	logic [OM_W-1:0]         om_s4;
	cx_t                     cx_s4;
	logic signed [OMF_W-1:0] omf_c;
	logic [OM_W-1:0]         om_c;
	logic [2:0][T_W-1:0]     t_c;

	always_comb begin
		omf_c = OMF_ONE - $signed({2'b00, dd_s3[DD_W-1:FRAC_BITS]});
		om_c  = (omf_c < OM_MIN) ? OM_W'(OM_MIN) : omf_c[OM_W-1:0];
		for (int i = 0; i < 3; i++) begin
			t_c[i] = T_W'($signed(d_s3.u[i])) - T_W'($signed(nd_s3[i][ND_W-1:FRAC_BITS]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s4 <= e2_s3;
			om_s4 <= om_c;
			cx_s4 <= '{t: t_c, n: d_s3.n, eta: d_s3.eta, tir: 1'b0};
		end
	end

	// stage 5: eta^2 * (1 - dt^2)
	logic                   vld_s5;
	logic [EO_W-1:0]        eo_s5;
	cx_t                    cx_s5;
	logic signed [EO_W-1:0] eo_c;

	assign eo_c = $signed({1'b0, e2_s4}) * $signed(om_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eo_s5 <= eo_c;
			cx_s5 <= cx_s4;
		end
	end

	// stage 6: discriminant, reflection flag, radicand of the second root
	logic                     vld_s6;
	logic [SX_W-1:0]          x_s6;
	cx_t                      cx_s6;
	logic signed [DISC_W-1:0] disc_c;
	logic                     tir_c;

	always_comb begin
		disc_c = DISC_ONE - DISC_W'($signed(eo_s5[EO_W-1:FRAC_BITS]));
		tir_c  = disc_c[DISC_W-1] || (disc_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6 <= tir_c ? '0 : {disc_c[SX_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			cx_s6 <= '{t: cx_s5.t, n: cx_s5.n, eta: cx_s5.eta, tir: tir_c};
		end
	end

	// root stages: STEP_PER_ST digits of sqrt(disc) in each
	rt_t  rt_s     [SQ_ST];
	logic rt_vld_s [SQ_ST];

	for (genvar k = 0; k < SQ_ST; k++) begin : g_rt
		rt_t  prv;
		rt_t  nxt;
		logic prv_vld;

		if (k == 0) begin : g_head
			assign prv     = '{st: '0, x: x_s6, cx: cx_s6};
			assign prv_vld = vld_s6;
		end else begin : g_body
			assign prv     = rt_s[k-1];
			assign prv_vld = rt_vld_s[k-1];
		end

		always_comb begin
			nxt = prv;
			for (int j = 0; j < STEP_PER_ST; j++) begin
				if (k * STEP_PER_ST + j < RT_W) begin
					nxt.st = sqrt_step(nxt.st, nxt.x[SX_W-1 -: 2]);
					nxt.x  = nxt.x << 2;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= nxt;
			end
		end
	end

	assign out_vld = rt_vld_s[SQ_ST-1];
	assign res     = '{t:   rt_s[SQ_ST-1].cx.t,
	                   n:   rt_s[SQ_ST-1].cx.n,
	                   eta: rt_s[SQ_ST-1].cx.eta,
	                   s:   rt_s[SQ_ST-1].st.root,
	                   tir: rt_s[SQ_ST-1].cx.tir};

	// a positive discriminant is at least one LSB, so its root is never zero
	`RRS_ASSERT_IMP(a_tir_root, clk, arst_n, out_vld, res.tir == (res.s == '0), "root disagrees with reflection flag")

endmodule

[rtl/rrs_out.sv]
// Output part: eta*t - n*sqrt(disc) per lane, saturation, output register.
// Depends on rrs_pkg.
module rrs_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  rrs_pkg::dsc_res_t          din,
	output logic                       out_vld,
	output logic [2:0][rrs_pkg::VW-1:0] dir_o,
	output logic                       valid_res
);
	import rrs_pkg::*;

	localparam logic signed [R_W-1:0] S_MAX = R_W'((longint'(1) <<< (VW - 1)) - 1);
	localparam logic signed [R_W-1:0] S_MIN = R_W'(-(longint'(1) <<< (VW - 1)));

	// stage 1: the two products of each lane
	logic                   vld_s1;
	logic                   tir_s1;
	logic [2:0][A_W-1:0]    a_s1;
	logic [2:0][B_W-1:0]    b_s1;
	logic signed [A_W-1:0]  a_c [3];
	logic signed [B_W-1:0]  b_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = $signed({1'b0, din.eta}) * $signed(din.t[i]);
			b_c[i] = $signed(din.n[i]) * $signed({1'b0, din.s});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s1 <= din.tir;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= a_c[i];
				b_s1[i] <= b_c[i];
			end
		end
	end

	// stage 2: floor, subtract, saturate; zero the word on total reflection
	logic                   vld_s2;
	logic                   valid_s2;
	logic [2:0][VW-1:0]     dir_s2;
	logic signed [R_W-1:0]  r_c [3];
	logic [2:0][VW-1:0]     sat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = R_W'($signed(a_s1[i][A_W-1:FRAC_BITS])) -
			         R_W'($signed(b_s1[i][B_W-1:FRAC_BITS]));
			if (tir_s1) begin
				sat_c[i] = '0;
			end else if (r_c[i] > S_MAX) begin
				sat_c[i] = S_MAX[VW-1:0];
			end else if (r_c[i] < S_MIN) begin
				sat_c[i] = S_MIN[VW-1:0];
			end else begin
				sat_c[i] = r_c[i][VW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s2   <= sat_c;
			valid_s2 <= !tir_s1;
		end
	end

	assign out_vld   = vld_s2;
	assign dir_o     = dir_s2;
	assign valid_res = valid_s2;

endmodule

[rtl/ray_refraction_snell.sv]
// Snell refraction of a ray direction about a surface normal, top level.
// Depends on rrs_pkg, rrs_norm, rrs_disc, rrs_out and ray_refraction_snell_assert.svh.
//
// Use: one ray word enters on s_axis (direction, unit normal, index ratio, all with
// 16 fraction bits) and one word leaves on m_axis with the refracted direction and a
// flag in m_axis_tuser: 1 when refraction exists, 0 on total internal reflection, in
// which case the three components are zero. Components saturate to 24 bits.
// A new word is taken in every cycle unless the receiver holds a finished word back;
// the two restoring square roots and the normalising divide run four digits per
// stage, which sets the pipeline depth.
// Every stage carries a valid bit. When the receiver holds m_axis_tready low while a
// word waits, the whole pipeline freezes and s_axis_tready drops in the same cycle;
// empty stages fill as long as the output register is free. Nothing is lost or
// repeated.
// Reset (arst_n low, asynchronous) empties the pipeline; no word is in flight after it.
`include "ray_refraction_snell_assert.svh"
module ray_refraction_snell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// dir_x, dir_y, dir_z, normal_x, normal_y, normal_z (24 each), index_ratio (20), pad 4
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x, out_y, out_z (24 each)
	output logic [71:0]  m_axis_tdata,
	// valid_res
	output logic         m_axis_tuser
);
	import rrs_pkg::*;

	logic                 en;
	logic [2:0][VW-1:0]   dir;
	logic [2:0][VW-1:0]   nrm;
	logic [EW-1:0]        eta;
	logic                 nrm_vld;
	nrm_res_t             nrm_res;
	logic                 dsc_vld;
	dsc_res_t             dsc_res;
	logic [2:0][VW-1:0]   out_dir;

	// advance the whole pipeline unless a finished word is held back
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// unpack the input word
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir[i] = s_axis_tdata[i*VW +: VW];
			nrm[i] = s_axis_tdata[(3+i)*VW +: VW];
		end
		eta = s_axis_tdata[6*VW +: EW];
	end

	rrs_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.dir     (dir),
		.nrm     (nrm),
		.eta     (eta),
		.out_vld (nrm_vld),
		.res     (nrm_res)
	);

	rrs_disc u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (nrm_vld),
		.din     (nrm_res),
		.out_vld (dsc_vld),
		.res     (dsc_res)
	);

	rrs_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (dsc_vld),
		.din       (dsc_res),
		.out_vld   (m_axis_tvalid),
		.dir_o     (out_dir),
		.valid_res (m_axis_tuser)
	);

	assign m_axis_tdata = out_dir;

	// total reflection must come out as an all-zero direction
	`RRS_ASSERT_IMP(a_tir_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "reflected word carries data")

endmodule

[tb/sv/ray_refraction_snell_tb.sv]
// Testbench for the Snell refraction pipeline: streams ray words, predicts each result.
// Depends on rrs_pkg and ray_refraction_snell; runs on its own.
module ray_refraction_snell_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrs_pkg::*;

	typedef struct packed {
		logic [23:0] dx, dy, dz, nx, ny, nz;
		logic [19:0] eta;
	} ray_t;

	typedef struct packed {
		logic [23:0] ox, oy, oz;
		logic        ok;
	} refr_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic         m_axis_tuser;

	ray_t  ray_q[$];
	refr_t refr_q[$];
	int    errors = 0;
	int    send_idle = 14;
	int    recv_idle = 87;
	int    hold_cycles = 0;
	bit    feeding = 1'b0;

	ray_refraction_snell dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat24(longint v);
		if (v > 64'sd8388607) return 8388607;
		if (v < -64'sd8388608) return -8388608;
		return v;
	endfunction

	// Work out the refracted direction of one ray word
	function automatic refr_t refract(ray_t w);
		longint v[3], n[3], u[3];
		longint eta, dt, dt2, om, e2, disc, s, t, r, one;
		longint unsigned sum, m, mag, q;
		refr_t res;
		one = 64'sd1 << FRAC_BITS;
		v[0] = signed'(w.dx); v[1] = signed'(w.dy); v[2] = signed'(w.dz);
		n[0] = signed'(w.nx); n[1] = signed'(w.ny); n[2] = signed'(w.nz);
		eta = longint'(w.eta);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += v[i] * v[i];
		m = isqrt(sum << 14);
		for (int i = 0; i < 3; i++) begin
			mag = v[i] < 0 ? -v[i] : v[i];
			q = 0;
			if (m != 0) begin
				q = (mag << (FRAC_BITS + 7)) / m;
				if (q > one) q = one;
			end
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		dt = fshift(u[0] * n[0] + u[1] * n[1] + u[2] * n[2], FRAC_BITS);
		dt2 = fshift(dt * dt, FRAC_BITS);
		om = one - dt2;
		if (om < -(64'sd1 << (FRAC_BITS + 20))) om = -(64'sd1 << (FRAC_BITS + 20));
		e2 = fshift(eta * eta, FRAC_BITS);
		disc = one - fshift(e2 * om, FRAC_BITS);
		res = '0;
		if (disc <= 0) return res;
		s = longint'(isqrt(longint'(disc) << FRAC_BITS));
		t = u[0] - fshift(n[0] * dt, FRAC_BITS);
		r = sat24(fshift(eta * t, FRAC_BITS) - fshift(n[0] * s, FRAC_BITS));
		res.ox = 24'(r);
		t = u[1] - fshift(n[1] * dt, FRAC_BITS);
		r = sat24(fshift(eta * t, FRAC_BITS) - fshift(n[1] * s, FRAC_BITS));
		res.oy = 24'(r);
		t = u[2] - fshift(n[2] * dt, FRAC_BITS);
		r = sat24(fshift(eta * t, FRAC_BITS) - fshift(n[2] * s, FRAC_BITS));
		res.oz = 24'(r);
		res.ok = 1'b1;
		return res;
	endfunction

	function automatic logic [23:0] rnd_comp(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($urandom_range(131072)) - 24'd65536;
			default: return 24'($urandom_range(4096)) - 24'd2048;
		endcase
	endfunction

	// Mostly unit-ish normals and moderate ratios, with some full-range noise
	function automatic ray_t rnd_ray();
		ray_t w;
		int sel, ax;
		sel = $urandom_range(9);
		w.dx = rnd_comp(sel == 0 ? 0 : $urandom_range(1, 2));
		w.dy = rnd_comp(sel == 0 ? 0 : $urandom_range(1, 2));
		w.dz = rnd_comp(sel == 0 ? 0 : $urandom_range(1, 2));
		if (sel < 2) begin
			w.nx = 24'($urandom); w.ny = 24'($urandom); w.nz = 24'($urandom);
			w.eta = 20'($urandom);
		end else begin
			ax = $urandom_range(2);
			w.nx = 24'($urandom_range(2000)) - 24'd1000;
			w.ny = 24'($urandom_range(2000)) - 24'd1000;
			w.nz = 24'($urandom_range(2000)) - 24'd1000;
			if (ax == 0) w.nx = $urandom_range(1) ? 24'd65536 : -24'd65536;
			if (ax == 1) w.ny = $urandom_range(1) ? 24'd65536 : -24'd65536;
			if (ax == 2) w.nz = $urandom_range(1) ? 24'd65536 : -24'd65536;
			w.eta = 20'($urandom_range(40000, 110000));
		end
		return w;
	endfunction

	// Drive: offer the next pending word, hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (ray_q.size() != 0 && feeding && $urandom_range(99) >= send_idle) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, ray_q[0].eta, ray_q[0].nz, ray_q[0].ny,
						ray_q[0].nx, ray_q[0].dz, ray_q[0].dy, ray_q[0].dx};
					refr_q.push_back(refract(ray_q.pop_front()));
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receive: stall at random, or for a long stretch while hold_cycles runs down
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Check each accepted word against the oldest prediction
	always @(posedge clk) begin
		refr_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48], m_axis_tuser};
			if (refr_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word %h", got);
			end else begin
				want = refr_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h %h %h %b, got %h %h %h %b",
							want.ox, want.oy, want.oz, want.ok,
							got.ox, got.oy, got.oz, got.ok);
				end
			end
		end
	end

	task automatic push_dir(logic [23:0] dx, dy, dz, nx, ny, nz, logic [19:0] eta);
		ray_q.push_back('{dx, dy, dz, nx, ny, nz, eta});
	endtask

	task automatic drain();
		while (ray_q.size() != 0 || s_axis_tvalid || refr_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// Directed words: zero direction, extremes, grazing, reflection, saturation
		push_dir(0, 0, 0, 0, 0, 24'd65536, 20'd65536);
		push_dir(0, 0, 0, 0, 24'd65536, 0, 20'd0);
		push_dir(24'd65536, 0, 0, 24'hFF0000, 0, 0, 20'd50000);
		push_dir(24'd65536, 24'd65536, 0, 0, 24'hFF0000, 0, 20'd98304);
		push_dir(24'd65536, 24'd10000, 0, 0, 24'hFF0000, 0, 20'd131072);
		push_dir(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			20'hFFFFF);
		push_dir(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
			20'hFFFFF);
		push_dir(24'h800000, 24'h7FFFFF, 24'd1, 24'h7FFFFF, 24'h800000, 24'd0, 20'd65536);
		push_dir(24'd1, 0, 0, 24'd65536, 0, 0, 20'd65536);
		push_dir(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 24'hFF0000, 20'd1);
		push_dir(0, 0, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 20'hFFFFF);
		push_dir(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hAAAAAA, 24'h555555, 24'hF0F0F0,
			20'hAAAAA);
		push_dir(24'd100, 24'd200, 24'hFFFF00, 24'd30000, 24'd40000, 24'd20000, 20'h55555);
		feeding = 1'b1;
		drain();
		// Random words in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 14 : (ph == 1) ? 87 : 0;
			recv_idle = (ph == 0) ? 87 : (ph == 1) ? 14 : 0;
			for (int k = 0; k < 267; k++) ray_q.push_back(rnd_ray());
			if (ph == 2) begin
				repeat (10) @(posedge clk);
				hold_cycles = 200;
			end
			drain();
		end
		repeat (60) @(posedge clk);
		if (errors == 0 && refr_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end
endmodule
